FILE: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the IGMP group extractor.
// Each macro expects signals named clock and reset in the calling scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define IGX_ASSERT(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error(msg);

// Check that an antecedent implies a consequent in the cycle after.
`define IGX_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/igx_pkg.sv
// Package for the IGMP group extractor: message type codes, result codes,
// well-known group addresses and the small classifier functions.
// Depends on nothing.
package igx_pkg;

   localparam logic [7:0] TYPE_QUERY     = 8'h11;
   localparam logic [7:0] TYPE_REPORT_V2 = 8'h16;
   localparam logic [7:0] TYPE_LEAVE     = 8'h17;
   localparam logic [7:0] TYPE_REPORT_V3 = 8'h22;

   localparam logic [1:0] STATUS_GROUP   = 2'd0;
   localparam logic [1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [1:0] STATUS_SHORT   = 2'd2;
   localparam logic [1:0] STATUS_UNKNOWN = 2'd3;

   localparam logic [1:0] KIND_REPORT_V2 = 2'd0;
   localparam logic [1:0] KIND_LEAVE     = 2'd1;
   localparam logic [1:0] KIND_REPORT_V3 = 2'd2;
   localparam logic [1:0] KIND_OTHER     = 2'd3;

   localparam logic [2:0] CLASS_SSDP          = 3'd0;
   localparam logic [2:0] CLASS_MDNS          = 3'd1;
   localparam logic [2:0] CLASS_SLP_GENERAL   = 3'd2;
   localparam logic [2:0] CLASS_SLP_DISCOVERY = 3'd3;
   localparam logic [2:0] CLASS_LISTED        = 3'd4;
   localparam logic [2:0] CLASS_SLP_ADMIN     = 3'd5;
   localparam logic [2:0] CLASS_UNLISTED      = 3'd6;

   localparam logic [31:0] ADDR_SSDP          = 32'heffffffa;
   localparam logic [31:0] ADDR_MDNS          = 32'he00000fb;
   localparam logic [31:0] ADDR_SLP_GENERAL   = 32'he0000116;
   localparam logic [31:0] ADDR_SLP_DISCOVERY = 32'he0000123;
   localparam logic [31:0] ADDR_LISTED        = 32'he4c8c8c9;
   localparam logic [31:0] ADDR_SLP_ADMIN     = 32'heffffffd;

   localparam logic [7:0]  FIRST_RECORD = 8'd8;

   function automatic logic [1:0] kind_of(input logic [7:0] msg_type);
      logic [1:0] kind;
      unique case (msg_type)
         TYPE_REPORT_V2: kind = KIND_REPORT_V2;
         TYPE_LEAVE:     kind = KIND_LEAVE;
         TYPE_REPORT_V3: kind = KIND_REPORT_V3;
         default:        kind = KIND_OTHER;
      endcase
      return kind;
   endfunction

   function automatic logic [2:0] class_of(input logic [31:0] addr);
      logic [2:0] cls;
      unique case (addr)
         ADDR_SSDP:          cls = CLASS_SSDP;
         ADDR_MDNS:          cls = CLASS_MDNS;
         ADDR_SLP_GENERAL:   cls = CLASS_SLP_GENERAL;
         ADDR_SLP_DISCOVERY: cls = CLASS_SLP_DISCOVERY;
         ADDR_LISTED:        cls = CLASS_LISTED;
         ADDR_SLP_ADMIN:     cls = CLASS_SLP_ADMIN;
         default:            cls = CLASS_UNLISTED;
      endcase
      return cls;
   endfunction

endpackage

FILE: rtl/igx_if.sv
// Valid/ready channel interfaces of the IGMP group extractor: byte beats in,
// group results out. Depends on nothing.
interface igx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       end_of_frame;

   modport source (output valid, data_byte, byte_valid, end_of_frame, input ready);
   modport sink   (input valid, data_byte, byte_valid, end_of_frame, output ready);
endinterface

interface igx_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [1:0]  message_kind;
   logic [31:0] group_ip;
   logic [2:0]  group_class;
   logic [15:0] record_number;

   modport source (output valid, status, message_kind, group_ip, group_class,
                   record_number, input ready);
   modport sink   (input valid, status, message_kind, group_ip, group_class,
                   record_number, output ready);
endinterface

FILE: rtl/igmp_group_extractor.sv
// IGMP group extractor top level: parses IGMP messages byte by byte and
// emits one result beat per group. Uses igx_pkg, igx_if and assert_macros.svh.
//
//   channel    dir  handshake           payload
//   req_chan   in   valid/ready         data_byte, byte_valid, end_of_frame
//   rsp_chan   out  valid/ready         status, message_kind, group_ip,
//                                       group_class, record_number
//
// One beat per cycle while the result is not stalled: a beat sits in the
// input register, then the parse logic updates the frame state and loads
// the result register, which drives rsp_chan.
// Synchronous reset clears both registers' valid flags and the frame state.
// A stalled result holds the input register; req_chan takes a new beat
// whenever the input register is empty or moves on in the same cycle.
`include "assert_macros.svh"

module igmp_group_extractor #(
   parameter int POSITION_WIDTH = 16
) (
   input  logic      clock,
   input  logic      reset,
   igx_req_if.sink   req_chan,
   igx_rsp_if.source rsp_chan
);

   localparam int NS_W  = POSITION_WIDTH + 4;
   localparam int SUM_W = ((NS_W > 19) ? NS_W : 19) + 1;
   localparam logic [POSITION_WIDTH-1:0] POS_MAX  = {POSITION_WIDTH{1'b1}};
   localparam logic [NS_W-1:0]           NEXT_CAP = {NS_W{1'b1}};

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_bv_ff;
   logic       in_eof_ff;

   logic [POSITION_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0]                type_ff, type_in;
   logic [31:0]               shift_ff, shift_in;
   logic [15:0]               rec_exp_ff, rec_exp_in;
   logic [15:0]               rec_done_ff, rec_done_in;
   logic [NS_W-1:0]           next_start_ff, next_start_in;
   logic [15:0]               src_ff, src_in;
   logic [7:0]                aux_ff, aux_in;

   logic        out_valid_ff;
   logic [1:0]  out_status_ff, out_status_in;
   logic [1:0]  out_kind_ff, out_kind_in;
   logic [31:0] out_addr_ff, out_addr_in;
   logic [2:0]  out_class_ff, out_class_in;
   logic [15:0] out_rec_ff, out_rec_in;
   logic        emit;

   logic advance;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign in_valid_in    = (req_chan.valid && req_chan.ready) || (in_valid_ff && !advance);

   always_comb begin
      logic              take;
      logic [31:0]       shift_new;
      logic [7:0]        type_eff;
      logic [NS_W-1:0]   pos_ext;
      logic [NS_W-1:0]   rel;
      logic [SUM_W-1:0]  sum;
      logic              in_record;

      pos_in        = pos_ff;
      type_in       = type_ff;
      shift_in      = shift_ff;
      rec_exp_in    = rec_exp_ff;
      rec_done_in   = rec_done_ff;
      next_start_in = next_start_ff;
      src_in        = src_ff;
      aux_in        = aux_ff;

      emit          = 1'b0;
      out_status_in = igx_pkg::STATUS_GROUP;
      out_addr_in   = '0;
      out_class_in  = igx_pkg::CLASS_UNLISTED;
      out_rec_in    = '0;

      take      = in_bv_ff && (pos_ff != POS_MAX);
      shift_new = {shift_ff[23:0], in_byte_ff};
      type_eff  = (take && pos_ff == '0) ? in_byte_ff : type_ff;
      pos_ext   = {4'b0000, pos_ff};
      rel       = pos_ext - next_start_ff;
      sum       = SUM_W'(next_start_ff) + SUM_W'({src_ff, 2'b00})
                  + SUM_W'({aux_ff, 2'b00}) + SUM_W'(igx_pkg::FIRST_RECORD);
      in_record = (type_ff == igx_pkg::TYPE_REPORT_V3) && (rec_done_ff < rec_exp_ff)
                  && (pos_ext >= next_start_ff);

      if (take) begin
         pos_in   = pos_ff + POSITION_WIDTH'(1);
         shift_in = shift_new;
         type_in  = type_eff;
         if (pos_ff == POSITION_WIDTH'(7)) begin
            unique case (type_ff)
               igx_pkg::TYPE_QUERY: begin
               end
               igx_pkg::TYPE_REPORT_V2, igx_pkg::TYPE_LEAVE: begin
                  emit         = 1'b1;
                  out_addr_in  = shift_new;
                  out_class_in = igx_pkg::class_of(shift_new);
               end
               igx_pkg::TYPE_REPORT_V3: begin
                  rec_exp_in = shift_new[15:0];
               end
               default: begin
                  emit          = 1'b1;
                  out_status_in = igx_pkg::STATUS_UNKNOWN;
               end
            endcase
         end else if (pos_ff > POSITION_WIDTH'(7) && in_record) begin
            priority if (rel == NS_W'(1)) begin
               aux_in = in_byte_ff;
            end else if (rel == NS_W'(2)) begin
               src_in = {in_byte_ff, 8'h00};
            end else if (rel == NS_W'(3)) begin
               src_in = {src_ff[15:8], in_byte_ff};
            end else if (rel == NS_W'(7)) begin
               emit          = 1'b1;
               out_addr_in   = shift_new;
               out_class_in  = igx_pkg::class_of(shift_new);
               out_rec_in    = rec_done_ff;
               rec_done_in   = rec_done_ff + 16'd1;
               next_start_in = (sum > SUM_W'(NEXT_CAP)) ? NEXT_CAP : sum[NS_W-1:0];
            end else begin
            end
         end
      end

      out_kind_in = igx_pkg::kind_of(type_eff);

      if (in_eof_ff) begin
         if (!emit) begin
            if (pos_in == '0) begin
               emit          = 1'b1;
               out_status_in = igx_pkg::STATUS_EMPTY;
            end else if (pos_in < POSITION_WIDTH'(8)) begin
               emit          = 1'b1;
               out_status_in = igx_pkg::STATUS_SHORT;
            end
         end
         pos_in        = '0;
         type_in       = '0;
         shift_in      = '0;
         rec_exp_in    = '0;
         rec_done_in   = '0;
         next_start_in = NS_W'(igx_pkg::FIRST_RECORD);
         src_in        = '0;
         aux_in        = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         pos_ff        <= '0;
         type_ff       <= '0;
         shift_ff      <= '0;
         rec_exp_ff    <= '0;
         rec_done_ff   <= '0;
         next_start_ff <= NS_W'(igx_pkg::FIRST_RECORD);
         src_ff        <= '0;
         aux_ff        <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            out_valid_ff  <= emit;
            pos_ff        <= pos_in;
            type_ff       <= type_in;
            shift_ff      <= shift_in;
            rec_exp_ff    <= rec_exp_in;
            rec_done_ff   <= rec_done_in;
            next_start_ff <= next_start_in;
            src_ff        <= src_in;
            aux_ff        <= aux_in;
         end else if (rsp_chan.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.valid && req_chan.ready) begin
         in_byte_ff <= req_chan.data_byte;
         in_bv_ff   <= req_chan.byte_valid;
         in_eof_ff  <= req_chan.end_of_frame;
      end
      if (advance && emit) begin
         out_status_ff <= out_status_in;
         out_kind_ff   <= out_kind_in;
         out_addr_ff   <= out_addr_in;
         out_class_ff  <= out_class_in;
         out_rec_ff    <= out_rec_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = out_status_ff;
   assign rsp_chan.message_kind  = out_kind_ff;
   assign rsp_chan.group_ip      = out_addr_ff;
   assign rsp_chan.group_class   = out_class_ff;
   assign rsp_chan.record_number = out_rec_ff;

   `IGX_ASSERT(a_records_bounded, rec_done_ff <= rec_exp_ff, "record count overrun")
   `IGX_ASSERT(a_walk_start, next_start_ff >= NS_W'(igx_pkg::FIRST_RECORD), "walk start low")
   `IGX_ASSERT(a_stall_only_full, req_chan.ready || in_valid_ff, "req stalled while empty")
   `IGX_ASSERT_NEXT(a_eof_clr, advance && in_eof_ff, pos_ff == '0 && rec_done_ff == '0, "state kept")

endmodule
